// ----- rtl/sjf_pkg.sv -----
// Shared constants, word types and controller states for the SJF scheduler.
package sjf_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int TICK_W   = 12;
  localparam int TIME_W   = 17;
  localparam int JOBNUM_W = 5;
  localparam int ENTRY_W  = 2 * TICK_W;
  localparam logic [TIME_W-1:0] CLOCK_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [TICK_W-1:0] arrival_time;
    logic [TICK_W-1:0] burst_time;
    logic              final_entry;
  } sjf_in_t;

  typedef struct packed {
    logic [JOBNUM_W-1:0] job_number;
    logic [TIME_W-1:0]   finish_time;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
    logic                last_result;
  } sjf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DECIDE,
    ST_EMIT
  } sjf_state_t;

endpackage

// ----- rtl/sjf_ram.sv -----
// Generic single-port synchronous RAM with registered read.
module sjf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/sjf_nonpreemptive_scheduler_top.sv -----
// Non-preemptive shortest-job-first scheduler: job store, scan controller and result output.
// Loading: one job word per cycle; busy stays low until the word marked final.
// Scheduling: each decision scans the stored jobs through the job RAM read port (ST_SCAN,
//   ST_SCAN_LAST, ST_DECIDE), then ST_EMIT for a job result or a rescan for an idle tick.
// A result strobe is registered in ST_EMIT, after ST_DECIDE picks its job; the receiver cannot stall.
// Reset (synchronous, active low) clears the job count, clock, done flags and state;
//   the job RAM is not cleared, and its read data is used only from written entries.
module sjf_nonpreemptive_scheduler_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sjf_pkg::sjf_in_t  in_data,
  output logic              out_valid,
  output sjf_pkg::sjf_out_t out_data
);
  import sjf_pkg::*;

  sjf_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    finished_r, finished_nxt;
  logic [TIME_W-1:0]   clock_r, clock_nxt;
  logic [MAX_JOBS-1:0] done_r, done_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [TICK_W-1:0]   best_burst_r, best_burst_nxt;
  logic [TICK_W-1:0]   best_arr_r, best_arr_nxt;
  logic                out_valid_r, out_valid_nxt;
  sjf_out_t            out_data_r, out_data_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [TICK_W-1:0]  rd_arr, rd_burst;
  logic               accept;
  logic               candidate;
  logic [TIME_W:0]    fin_sum;
  logic [TIME_W-1:0]  tat;
  logic [TIME_W-1:0]  burst_ext;

  sjf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign accept    = start && (state_r == ST_IDLE);
  assign ram_wdata = {in_data.arrival_time, in_data.burst_time};
  assign rd_arr    = ram_rdata[ENTRY_W-1:TICK_W];
  assign rd_burst  = ram_rdata[TICK_W-1:0];
  assign candidate = rd_v_r && !done_r[rd_idx_r] &&
                     (TIME_W'(rd_arr) <= clock_r) &&
                     (!found_r || (rd_burst < best_burst_r));
  assign fin_sum   = {1'b0, clock_r} + (TIME_W + 1)'(best_burst_r);
  assign burst_ext = TIME_W'(best_burst_r);
  assign tat       = clock_r - TIME_W'(best_arr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      finished_r  <= '0;
      clock_r     <= '0;
      done_r      <= '0;
      scan_idx_r  <= '0;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      finished_r  <= finished_nxt;
      clock_r     <= clock_nxt;
      done_r      <= done_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rd_v_r      <= rd_v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_burst_r <= best_burst_nxt;
    best_arr_r   <= best_arr_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    finished_nxt   = finished_r;
    clock_nxt      = clock_r;
    done_nxt       = done_r;
    scan_idx_nxt   = scan_idx_r;
    rd_v_nxt       = 1'b0;
    rd_idx_nxt     = scan_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_burst_nxt = best_burst_r;
    best_arr_nxt   = best_arr_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_addr       = scan_idx_r;

    if (candidate) begin
      found_nxt      = 1'b1;
      best_idx_nxt   = rd_idx_r;
      best_burst_nxt = rd_burst;
      best_arr_nxt   = rd_arr;
    end

    case (state_r)
      ST_IDLE: begin
        ram_addr = count_r[IDX_W-1:0];
        if (accept) begin
          if (count_r < CNT_W'(MAX_JOBS)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_data.final_entry) begin
            state_nxt    = ST_SCAN;
            scan_idx_nxt = '0;
            found_nxt    = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        rd_v_nxt = 1'b1;
        if (CNT_W'({1'b0, scan_idx_r}) + CNT_W'(1) == count_r) begin
          state_nxt = ST_SCAN_LAST;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      ST_SCAN_LAST: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (found_r) begin
          clock_nxt = fin_sum[TIME_W] ? CLOCK_MAX : fin_sum[TIME_W-1:0];
          state_nxt = ST_EMIT;
        end else begin
          if (clock_r != CLOCK_MAX) begin
            clock_nxt = clock_r + TIME_W'(1);
          end
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
        end
      end
      ST_EMIT: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.job_number  = JOBNUM_W'(32'(best_idx_r) + 1);
        out_data_nxt.finish_time = clock_r;
        out_data_nxt.turnaround  = tat;
        out_data_nxt.waiting     = (tat >= burst_ext) ? (tat - burst_ext) : '0;
        out_data_nxt.last_result = (finished_r + CNT_W'(1) == count_r);
        done_nxt[best_idx_r]     = 1'b1;
        finished_nxt             = finished_r + CNT_W'(1);
        if (finished_r + CNT_W'(1) == count_r) begin
          state_nxt    = ST_IDLE;
          count_nxt    = '0;
          finished_nxt = '0;
          clock_nxt    = '0;
          done_nxt     = '0;
        end else begin
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/sjf_checker.sv -----
// Port-level checks for the SJF scheduler and their binding to the top level.
module sjf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input sjf_pkg::sjf_in_t  in_data,
  input logic              out_valid,
  input sjf_pkg::sjf_out_t out_data
);
  import sjf_pkg::*;

  a_strobe_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes on adjacent cycles");

  a_more_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> busy)
    else $error("scheduler idle before the last result");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |-> !busy)
    else $error("scheduler still busy after the last result");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_data.final_entry |=> !busy && !out_valid)
    else $error("loading a word left the idle state");

  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.final_entry |=> busy)
    else $error("final word did not start scheduling");

endmodule

bind sjf_nonpreemptive_scheduler_top sjf_checker u_sjf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the SJF scheduler: job loading, schedule prediction, result checks.
module tb_top;
  import sjf_pkg::*;

  localparam int STALL_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 64;
  localparam int TICK_MAX      = (1 << TICK_W) - 1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  sjf_in_t  in_data = '0;
  logic     out_valid;
  sjf_out_t out_data;

  logic [TICK_W-1:0] arrival_mem [MAX_JOBS];
  logic [TICK_W-1:0] burst_mem [MAX_JOBS];
  bit                job_done [MAX_JOBS];
  int unsigned       jobs_loaded = 0;
  int unsigned       sched_clock = 0;
  int unsigned       jobs_finished = 0;
  sjf_out_t          pending_results [$];
  sjf_out_t          oldest_result;

  int sender_idle_pct = 0;
  int mismatches = 0;
  int jobs_sent = 0;
  int sets_scheduled = 0;
  int results_seen = 0;
  int stall_cycles = 0;

  sjf_nonpreemptive_scheduler_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void schedule_set();
    bit          found;
    int unsigned pick;
    int unsigned best;
    int unsigned fin;
    int unsigned tat;
    int unsigned wt;
    sjf_out_t    r;
    while (jobs_finished < jobs_loaded) begin
      found = 1'b0;
      pick = 0;
      best = 0;
      for (int k = 0; k < jobs_loaded; k++) begin
        if (!job_done[k] && arrival_mem[k] <= sched_clock && (!found || burst_mem[k] < best)) begin
          found = 1'b1;
          best = burst_mem[k];
          pick = k;
        end
      end
      if (!found) begin
        if (sched_clock < CLOCK_MAX) sched_clock++;
      end else begin
        fin = sched_clock + best;
        if (fin > CLOCK_MAX) fin = CLOCK_MAX;
        sched_clock = fin;
        job_done[pick] = 1'b1;
        jobs_finished++;
        tat = fin - arrival_mem[pick];
        wt = (tat >= best) ? tat - best : 0;
        r.job_number = JOBNUM_W'(pick + 1);
        r.finish_time = TIME_W'(fin);
        r.turnaround = TIME_W'(tat);
        r.waiting = TIME_W'(wt);
        r.last_result = (jobs_finished == jobs_loaded);
        pending_results.push_back(r);
      end
    end
  endfunction

  function automatic void load_job_word(sjf_in_t w);
    if (jobs_loaded < MAX_JOBS) begin
      arrival_mem[jobs_loaded] = w.arrival_time;
      burst_mem[jobs_loaded] = w.burst_time;
      job_done[jobs_loaded] = 1'b0;
      jobs_loaded++;
    end
    if (w.final_entry) begin
      schedule_set();
      sets_scheduled++;
      foreach (job_done[k]) job_done[k] = 1'b0;
      jobs_loaded = 0;
      sched_clock = 0;
      jobs_finished = 0;
    end
  endfunction

  function automatic void report_mismatch(string why, sjf_out_t want, sjf_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected job %0d fin %0d tat %0d wait %0d last %0d", $realtime, why,
               want.job_number, want.finish_time, want.turnaround, want.waiting,
               want.last_result);
      $display("    got job %0d fin %0d tat %0d wait %0d last %0d", got.job_number,
               got.finish_time, got.turnaround, got.waiting, got.last_result);
    end
  endfunction

  function automatic logic [TICK_W-1:0] random_tick(int full_odds, int small_max);
    if ($urandom_range(0, full_odds - 1) == 0) return TICK_W'($urandom_range(0, TICK_MAX));
    return TICK_W'($urandom_range(0, small_max));
  endfunction

  task automatic send_job(input int arrival, input int burst, input bit last);
    sjf_in_t w;
    w.arrival_time = TICK_W'(arrival);
    w.burst_time = TICK_W'(burst);
    w.final_entry = last;
    in_data <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    load_job_word(w);
    jobs_sent++;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_extreme_fields();
    send_job(TICK_MAX, TICK_MAX, 1'b1);
    send_job(0, TICK_MAX, 1'b0);
    send_job(TICK_MAX, 0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_zero_burst();
    send_job(0, 0, 1'b0);
    send_job(0, 0, 1'b0);
    send_job(3, 0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_burst_ties();
    send_job(2, 5, 1'b0);
    send_job(0, 5, 1'b0);
    send_job(0, 5, 1'b0);
    send_job(1, 1, 1'b1);
    wait_for_results();
  endtask

  task automatic test_capacity_overflow();
    for (int k = 0; k < MAX_JOBS; k++) send_job((k * 5) % 23, (k * 7) % 13, 1'b0);
    send_job(TICK_MAX, TICK_MAX, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_sets(input int idle_pct, input int n_items);
    int sent;
    int set_size;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 7))
        0: set_size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
        1, 2: set_size = $urandom_range(1, MAX_JOBS);
        default: set_size = $urandom_range(1, 6);
      endcase
      for (int j = 0; j < set_size; j++) begin
        send_job(random_tick(16, 40), random_tick(8, 24), j == set_size - 1);
      end
      sent += set_size;
    end
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.job_number !== oldest_result.job_number ||
            out_data.finish_time !== oldest_result.finish_time ||
            out_data.turnaround !== oldest_result.turnaround ||
            out_data.waiting !== oldest_result.waiting ||
            out_data.last_result !== oldest_result.last_result) begin
          report_mismatch("result mismatch", oldest_result, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("sjf_nonpreemptive_scheduler_top verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct = 21;
    test_extreme_fields();
    test_zero_burst();
    test_burst_ties();
    test_capacity_overflow();
    test_random_sets(21, 50);
    test_random_sets(81, 50);
    test_random_sets(0, 50);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Loaded %0d jobs in %0d scheduled sets, %0d results checked, %0d mismatches.",
             jobs_sent, sets_scheduled, results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sjf_nonpreemptive_scheduler_top verification clean");
    end else begin
      $display("sjf_nonpreemptive_scheduler_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sjf_nonpreemptive_scheduler_top.f -----
rtl/sjf_pkg.sv
rtl/sjf_ram.sv
rtl/sjf_nonpreemptive_scheduler_top.sv
rtl/sjf_checker.sv
dv/tb_top.sv
